// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the dispatcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ESJD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ESJD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/esjd_pkg.sv =====
// ----------------------------------------------------------------------------
// Dispatcher package
// Types, codes and helper functions shared by the job dispatcher files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esjd_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    localparam logic STATUS_DONE   = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] start;
        logic [31:0] run;
        logic [31:0] order;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SIFT_UP,
        ST_UP_WAIT,
        ST_DISP_RD,
        ST_DISP_WAIT,
        ST_DOWN_RD,
        ST_DOWN_WAIT,
        ST_FINISH
    } state_t;

    // An entry ranks first when it starts earlier, or starts at the same tick
    // and arrived earlier. Arrival age is taken relative to the next arrival
    // number so that wrap of the counter does not matter.
    function automatic logic key_less(entry_t a, entry_t b, logic [31:0] seq);
        logic [31:0] age_a;
        logic [31:0] age_b;
        age_a = seq - a.order;
        age_b = seq - b.order;
        return (a.start < b.start) || ((a.start == b.start) && (age_a > age_b));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/esjd_in_if.sv =====
// ----------------------------------------------------------------------------
// Dispatcher input channel
// Valid/ready channel that carries schedule and tick requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface esjd_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] job_id;
    logic [31:0] start_tick;
    logic [31:0] run_ticks;

    modport source (output valid, output command, output job_id, output start_tick,
                    output run_ticks, input ready);
    modport sink (input valid, input command, input job_id, input start_tick,
                  input run_ticks, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/esjd_out_if.sv =====
// ----------------------------------------------------------------------------
// Dispatcher output channel
// Valid/ready channel that carries finished and rejected job reports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface esjd_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [15:0] done_id;

    modport source (output valid, output status, output done_id, input ready);
    modport sink (input valid, input status, input done_id, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/esjd_heap_ram.sv =====
// ----------------------------------------------------------------------------
// Heap storage
// One write port and two registered read ports over the pending job entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esjd_heap_ram #(
    parameter int QUEUE_DEPTH = esjd_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [IDX_W-1:0]   wr_addr,
    input  wire esjd_pkg::entry_t   wr_data,
    input  wire logic [IDX_W-1:0]   rd_addr_a,
    input  wire logic [IDX_W-1:0]   rd_addr_b,
    output esjd_pkg::entry_t        rd_data_a,
    output esjd_pkg::entry_t        rd_data_b
);

    esjd_pkg::entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/core/earliest_start_job_dispatcher_unit.sv =====
// ----------------------------------------------------------------------------
// Earliest start job dispatcher
// Single-worker job queue kept as a binary min-heap in block memory.
// ----------------------------------------------------------------------------
// Requests are taken one at a time while the block is idle. Every request
// is taken in the idle state and ends in a closing finish state in which
// its report, if any, moves to the output register; a rejected schedule
// request needs nothing more. An accepted schedule request climbs the heap
// one level per read of the parent, ending with the final write, while a
// tick request goes straight on. The dispatch check that follows goes
// straight to the closing state when the worker is busy or the queue is
// empty and otherwise reads the head, and a dispatch that leaves jobs
// queued then walks the heap down one level per read of the children,
// ending with the final write. The closing state repeats while a report is
// pending and the previous report has not been taken. A report waits in an
// output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module earliest_start_job_dispatcher_unit #(
    parameter int QUEUE_DEPTH = esjd_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    esjd_in_if.sink      in_chan,
    esjd_out_if.source   out_chan
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CW    = IDX_W + 2;

    esjd_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      seq_reg, seq_next;
    logic [31:0]      now_reg, now_next;
    logic             busy_reg, busy_next;
    logic [15:0]      run_id_reg, run_id_next;
    logic [31:0]      rem_reg, rem_next;
    logic [IDX_W-1:0] hole_reg, hole_next;
    esjd_pkg::entry_t item_reg, item_next;
    logic             res_pend_reg, res_pend_next;
    logic             res_status_reg, res_status_next;
    logic [15:0]      res_id_reg, res_id_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_status_reg, out_status_next;
    logic [15:0]      out_id_reg, out_id_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    esjd_pkg::entry_t wr_data;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    esjd_pkg::entry_t rd_data_a;
    esjd_pkg::entry_t rd_data_b;

    logic             in_fire;
    logic             slot_free;
    logic             queue_full;
    logic [CNT_W-1:0] cnt_dec;
    logic [IDX_W-1:0] parent_idx;
    logic [CW-1:0]    left_idx;
    logic [CW-1:0]    right_idx;
    logic             left_ok;
    logic             right_ok;
    logic             up_move;
    logic             head_due;
    logic             pick_right;
    esjd_pkg::entry_t pick_entry;
    logic             down_move;

    esjd_heap_ram #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_heap_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign in_chan.ready   = (state_reg == esjd_pkg::ST_IDLE);
    assign in_fire         = in_chan.valid && in_chan.ready;
    assign out_chan.valid  = out_valid_reg;
    assign out_chan.status = out_status_reg;
    assign out_chan.done_id = out_id_reg;

    assign slot_free  = !out_valid_reg || out_chan.ready;
    assign queue_full = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign cnt_dec    = cnt_reg - 1'b1;
    assign parent_idx = (hole_reg - 1'b1) >> 1;
    assign left_idx   = {1'b0, hole_reg, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign left_ok    = left_idx < CW'(cnt_reg);
    assign right_ok   = right_idx < CW'(cnt_reg);
    assign up_move    = esjd_pkg::key_less(item_reg, rd_data_a, seq_reg);
    assign head_due   = rd_data_a.start <= now_reg;
    assign pick_right = right_ok && esjd_pkg::key_less(rd_data_b, rd_data_a, seq_reg);
    assign pick_entry = pick_right ? rd_data_b : rd_data_a;
    assign down_move  = esjd_pkg::key_less(pick_entry, item_reg, seq_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            esjd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_chan.command == esjd_pkg::CMD_SCHEDULE)
                    begin
                        state_next = queue_full ? esjd_pkg::ST_FINISH : esjd_pkg::ST_SIFT_UP;
                    end
                    else
                    begin
                        state_next = esjd_pkg::ST_DISP_RD;
                    end
                end
            end
            esjd_pkg::ST_SIFT_UP:
            begin
                state_next = (hole_reg == '0) ? esjd_pkg::ST_DISP_RD : esjd_pkg::ST_UP_WAIT;
            end
            esjd_pkg::ST_UP_WAIT:
            begin
                state_next = up_move ? esjd_pkg::ST_SIFT_UP : esjd_pkg::ST_DISP_RD;
            end
            esjd_pkg::ST_DISP_RD:
            begin
                state_next = (!busy_reg && cnt_reg != '0) ? esjd_pkg::ST_DISP_WAIT
                                                          : esjd_pkg::ST_FINISH;
            end
            esjd_pkg::ST_DISP_WAIT:
            begin
                state_next = (head_due && cnt_dec != '0) ? esjd_pkg::ST_DOWN_RD
                                                         : esjd_pkg::ST_FINISH;
            end
            esjd_pkg::ST_DOWN_RD:
            begin
                state_next = left_ok ? esjd_pkg::ST_DOWN_WAIT : esjd_pkg::ST_FINISH;
            end
            esjd_pkg::ST_DOWN_WAIT:
            begin
                state_next = down_move ? esjd_pkg::ST_DOWN_RD : esjd_pkg::ST_FINISH;
            end
            esjd_pkg::ST_FINISH:
            begin
                if (!res_pend_reg || slot_free)
                begin
                    state_next = esjd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = esjd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        seq_next        = seq_reg;
        now_next        = now_reg;
        busy_next       = busy_reg;
        run_id_next     = run_id_reg;
        rem_next        = rem_reg;
        hole_next       = hole_reg;
        item_next       = item_reg;
        res_pend_next   = res_pend_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        out_valid_next  = out_valid_reg && !out_chan.ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        wr_en           = 1'b0;
        wr_addr         = hole_reg;
        wr_data         = item_reg;
        rd_addr_a       = '0;
        rd_addr_b       = '0;
        unique case (state_reg)
            esjd_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_pend_next = 1'b0;
                    if (in_chan.command == esjd_pkg::CMD_SCHEDULE)
                    begin
                        if (queue_full)
                        begin
                            res_pend_next   = 1'b1;
                            res_status_next = esjd_pkg::STATUS_REJECT;
                            res_id_next     = in_chan.job_id;
                        end
                        else
                        begin
                            item_next.id    = in_chan.job_id;
                            item_next.start = in_chan.start_tick;
                            item_next.run   = in_chan.run_ticks;
                            item_next.order = seq_reg;
                            seq_next        = seq_reg + 1'b1;
                            hole_next       = cnt_reg[IDX_W-1:0];
                            cnt_next        = cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (now_reg != '1)
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        if (busy_reg)
                        begin
                            rem_next = (rem_reg == '0) ? '0 : rem_reg - 1'b1;
                            if (rem_reg <= 32'd1)
                            begin
                                res_pend_next   = 1'b1;
                                res_status_next = esjd_pkg::STATUS_DONE;
                                res_id_next     = run_id_reg;
                                busy_next       = 1'b0;
                            end
                        end
                    end
                end
            end
            esjd_pkg::ST_SIFT_UP:
            begin
                if (hole_reg == '0)
                begin
                    wr_en = 1'b1;
                end
                else
                begin
                    rd_addr_a = parent_idx;
                end
            end
            esjd_pkg::ST_UP_WAIT:
            begin
                wr_en = 1'b1;
                if (up_move)
                begin
                    wr_data   = rd_data_a;
                    hole_next = parent_idx;
                end
            end
            esjd_pkg::ST_DISP_RD:
            begin
                rd_addr_a = '0;
                rd_addr_b = cnt_dec[IDX_W-1:0];
            end
            esjd_pkg::ST_DISP_WAIT:
            begin
                if (head_due)
                begin
                    run_id_next = rd_data_a.id;
                    rem_next    = (rd_data_a.run == '0) ? 32'd1 : rd_data_a.run;
                    busy_next   = 1'b1;
                    cnt_next    = cnt_dec;
                    item_next   = rd_data_b;
                    hole_next   = '0;
                end
            end
            esjd_pkg::ST_DOWN_RD:
            begin
                if (left_ok)
                begin
                    rd_addr_a = left_idx[IDX_W-1:0];
                    rd_addr_b = right_ok ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
                end
                else
                begin
                    wr_en = 1'b1;
                end
            end
            esjd_pkg::ST_DOWN_WAIT:
            begin
                wr_en = 1'b1;
                if (down_move)
                begin
                    wr_data   = pick_entry;
                    hole_next = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
                end
            end
            esjd_pkg::ST_FINISH:
            begin
                if (res_pend_reg && slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    res_pend_next   = 1'b0;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= esjd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            seq_reg       <= '0;
            now_reg       <= '0;
            busy_reg      <= 1'b0;
            run_id_reg    <= '0;
            rem_reg       <= '0;
            res_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seq_reg       <= seq_next;
            now_reg       <= now_next;
            busy_reg      <= busy_next;
            run_id_reg    <= run_id_next;
            rem_reg       <= rem_next;
            res_pend_reg  <= res_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg       <= hole_next;
        item_reg       <= item_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
    end

    `ESJD_ASSERT(a_count_bound, clk, rst_n, cnt_reg <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
    `ESJD_ASSERT_IMPL(a_busy_remaining, clk, rst_n, busy_reg, rem_reg != '0, "busy with no ticks left")
    `ESJD_ASSERT_IMPL(a_write_in_heap, clk, rst_n, wr_en, CW'(wr_addr) < CW'(cnt_reg), "heap write beyond count")
    `ESJD_ASSERT_IMPL(a_report_source, clk, rst_n, $rose(out_valid_reg), $past(state_reg == esjd_pkg::ST_FINISH), "report raised outside finish")

endmodule

`default_nettype wire

// ===== sim/dispatch_checker.sv =====
// ----------------------------------------------------------------------------
// Dispatcher checker
// Watches the request and report channels of the job dispatcher, keeps its
// own copy of the pending queue, the time counter and the worker, and
// compares every report against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dispatch_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    esjd_in_if        in_chan,
    esjd_out_if       out_chan,
    output int        mismatches,
    output int        outstanding
);

    typedef struct {
        logic [15:0] id;
        logic [31:0] start;
        logic [31:0] run;
    } job_t;

    typedef struct {
        logic        status;
        logic [15:0] id;
    } report_t;

    job_t        queued_jobs[$];
    report_t     expected_reports[$];
    logic [31:0] now_ticks;
    logic        worker_busy;
    logic [15:0] running_id;
    logic [31:0] remaining_ticks;

    task automatic start_next_job();
        job_t head;
        if (!worker_busy && queued_jobs.size() != 0 && queued_jobs[0].start <= now_ticks)
        begin
            head = queued_jobs.pop_front();
            running_id = head.id;
            remaining_ticks = (head.run == 32'd0) ? 32'd1 : head.run;
            worker_busy = 1'b1;
        end
    endtask

    task automatic step_job_queue(input logic cmd, input logic [15:0] id,
                                  input logic [31:0] start, input logic [31:0] run);
        job_t    job;
        report_t rpt;
        int      pos;
        if (cmd == esjd_pkg::CMD_SCHEDULE)
        begin
            if (queued_jobs.size() >= esjd_pkg::DEFAULT_QUEUE_DEPTH)
            begin
                rpt.status = esjd_pkg::STATUS_REJECT;
                rpt.id = id;
                expected_reports.push_back(rpt);
            end
            else
            begin
                job.id = id;
                job.start = start;
                job.run = run;
                pos = queued_jobs.size();
                while (pos > 0 && queued_jobs[pos - 1].start > start)
                    pos--;
                queued_jobs.insert(pos, job);
                start_next_job();
            end
        end
        else
        begin
            if (now_ticks != 32'hFFFF_FFFF)
                now_ticks = now_ticks + 32'd1;
            if (worker_busy)
            begin
                if (remaining_ticks != 32'd0)
                    remaining_ticks = remaining_ticks - 32'd1;
                if (remaining_ticks == 32'd0)
                begin
                    rpt.status = esjd_pkg::STATUS_DONE;
                    rpt.id = running_id;
                    expected_reports.push_back(rpt);
                    worker_busy = 1'b0;
                end
            end
            start_next_job();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n)
        begin
            queued_jobs.delete();
            expected_reports.delete();
            now_ticks = 32'd0;
            worker_busy = 1'b0;
            running_id = 16'd0;
            remaining_ticks = 32'd0;
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_chan.valid && out_chan.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $display("%0t: unexpected report: expected none, got status %0d id %h",
                             $time, out_chan.status, out_chan.done_id);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (out_chan.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, out_chan.status);
                        mismatches++;
                    end
                    if (out_chan.done_id !== want.id)
                    begin
                        $display("%0t: done_id mismatch: expected %h, got %h",
                                 $time, want.id, out_chan.done_id);
                        mismatches++;
                    end
                end
            end
            if (in_chan.valid && in_chan.ready)
                step_job_queue(in_chan.command, in_chan.job_id, in_chan.start_tick,
                               in_chan.run_ticks);
            outstanding = expected_reports.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Job dispatcher testbench
// Drives schedule and tick requests into the dispatcher with random gaps and
// report back-pressure, first a directed set covering field extremes, ties,
// a full queue and stray tick fields, then random traffic whose start ticks
// follow the running time. A separate checker does the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_REQUESTS = 700;
    localparam int QUIET_TAIL      = 100;
    localparam int STALL_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_PARKED      = 3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    bit          quiet = 1'b0;
    int          ready_hold;
    int          idle_cycles;
    int          mismatches;
    int          outstanding;
    int          parked_jobs;
    int          tick_pct;
    logic [31:0] now_est;
    logic [15:0] rand_id;
    logic [31:0] rand_start;
    logic [31:0] rand_run;

    esjd_in_if  req_chan ();
    esjd_out_if rpt_chan ();

    earliest_start_job_dispatcher_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (req_chan),
        .out_chan (rpt_chan)
    );

    dispatch_checker dispatch_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_chan     (req_chan),
        .out_chan    (rpt_chan),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #6 clk = ~clk;

    task automatic send_request(input logic cmd, input logic [15:0] id,
                                input logic [31:0] start, input logic [31:0] run);
        req_chan.valid = 1'b1;
        req_chan.command = cmd;
        req_chan.job_id = id;
        req_chan.start_tick = start;
        req_chan.run_ticks = run;
        @(posedge clk);
        while (!req_chan.ready)
            @(posedge clk);
        if (cmd == esjd_pkg::CMD_TICK)
            now_est = now_est + 32'd1;
        @(negedge clk);
    endtask

    initial
    begin
        ready_hold = 0;
        rpt_chan.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                rpt_chan.ready = 1'b0;
                ready_hold--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                rpt_chan.ready = 1'b0;
                ready_hold = $urandom_range(1, 6) - 1;
            end
            else
                rpt_chan.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_chan.valid && req_chan.ready) || (rpt_chan.valid && rpt_chan.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
        else
            idle_cycles = 0;
    end

    initial
    begin
        req_chan.valid = 1'b0;
        req_chan.command = esjd_pkg::CMD_SCHEDULE;
        req_chan.job_id = 16'd0;
        req_chan.start_tick = 32'd0;
        req_chan.run_ticks = 32'd0;
        now_est = 32'd0;
        parked_jobs = 0;
        tick_pct = 50;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // A tick with every other field set must be ignored apart from the time step.
        send_request(esjd_pkg::CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(esjd_pkg::CMD_SCHEDULE, 16'h0000, 32'd0, 32'd0);
        send_request(esjd_pkg::CMD_TICK, 16'h0000, 32'd0, 32'd0);
        // This job can never start, so it holds one queue slot for the whole run.
        send_request(esjd_pkg::CMD_SCHEDULE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(esjd_pkg::CMD_SCHEDULE, 16'hA001, now_est + 32'd3, 32'd1);
        send_request(esjd_pkg::CMD_SCHEDULE, 16'hA002, now_est + 32'd3, 32'd1);
        send_request(esjd_pkg::CMD_SCHEDULE, 16'hA003, now_est + 32'd2, 32'd0);
        for (int k = 0; k < 12; k++)
            send_request(esjd_pkg::CMD_SCHEDULE, 16'hB000 + 16'(k), 32'd10 + 32'(k), 32'd0);
        send_request(esjd_pkg::CMD_SCHEDULE, 16'hEEEE, 32'd0, 32'd5);
        repeat (5)
            send_request(esjd_pkg::CMD_TICK, 16'($urandom), $urandom, $urandom);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 50 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: tick_pct = 30;
                    1: tick_pct = 60;
                    default: tick_pct = 80;
                endcase
            end
            quiet = (n >= RANDOM_REQUESTS - QUIET_TAIL);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                req_chan.valid = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            if ($urandom_range(0, 99) < tick_pct)
                send_request(esjd_pkg::CMD_TICK, 16'($urandom), $urandom, $urandom);
            else
            begin
                rand_id = 16'($urandom);
                if (parked_jobs < MAX_PARKED && $urandom_range(0, 59) == 0)
                begin
                    rand_start = $urandom | 32'h8000_0000;
                    rand_run = $urandom;
                    parked_jobs++;
                end
                else
                begin
                    case ($urandom_range(0, 9))
                        0: rand_start = 32'd0;
                        1, 2: rand_start = $urandom_range(0, now_est);
                        default: rand_start = now_est + $urandom_range(0, 12);
                    endcase
                    if ($urandom_range(0, 9) < 8)
                        rand_run = $urandom_range(0, 4);
                    else
                        rand_run = $urandom_range(5, 30);
                end
                send_request(esjd_pkg::CMD_SCHEDULE, rand_id, rand_start, rand_run);
            end
        end

        req_chan.valid = 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
